FILE: rtl/core/smeu_pkg.sv
// Shared types and constants of the stack machine execute unit.
// No dependencies; imported by every module of the block.
`default_nettype none
package smeu_pkg;

	localparam int WORD_W = 32;
	localparam int IP_W   = 16;
	localparam int TGT_W  = 17;
	localparam int RIDX_W = 8;

	typedef enum logic [3:0] {
		OP_HALT = 4'd0,
		OP_DISP = 4'd1,
		OP_PUSH = 4'd2,
		OP_POP  = 4'd3,
		OP_MOV  = 4'd4,
		OP_CALL = 4'd5,
		OP_RET  = 4'd6,
		OP_JMP  = 4'd7,
		OP_JZ   = 4'd8,
		OP_JPOS = 4'd9,
		OP_JNEG = 4'd10,
		OP_ADD  = 4'd11,
		OP_SUB  = 4'd12,
		OP_MUL  = 4'd13,
		OP_DIV  = 4'd14,
		OP_NOP  = 4'd15
	} op_t;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_BADREG  = 3'd3;
	localparam logic [2:0] ST_OVF     = 3'd4;
	localparam logic [2:0] ST_DIVZERO = 3'd5;
	localparam logic [2:0] ST_BADTGT  = 3'd6;
	localparam logic [2:0] ST_HALT    = 3'd7;

	localparam logic [IP_W-1:0]   RET_OFS   = 16'd2;
	localparam logic [IP_W-1:0]   PLEN_RST  = 16'hFFFF;
	localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
	localparam logic [WORD_W-1:0] WORD_NEG1 = 32'hFFFF_FFFF;

	// classified instruction as held in the front/back queue
	typedef struct packed {
		op_t               op;
		logic [RIDX_W-1:0] ra;
		logic [RIDX_W-1:0] rb;
		logic [WORD_W-1:0] imm;
		logic [IP_W-1:0]   ip;
		logic [IP_W-1:0]   tgt;
		logic              a_ok;
		logic              b_ok;
		logic              tgt_ok;
	} instr_t;

endpackage
`default_nettype wire

FILE: rtl/core/smeu_front.sv
// Front end: accepts instruction transactions, classifies them and queues them.
// Depends on smeu_pkg.
`default_nettype none
module smeu_front #(
	parameter int NUM_REGS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [3:0]                  req_type,
	input  logic [smeu_pkg::RIDX_W-1:0] reg_a,
	input  logic [smeu_pkg::RIDX_W-1:0] reg_b,
	input  logic [smeu_pkg::WORD_W-1:0] immediate,
	input  logic [smeu_pkg::TGT_W-1:0]  jump_target,
	input  logic [smeu_pkg::IP_W-1:0]   current_ip,
	input  logic [smeu_pkg::IP_W-1:0]   program_length,
	input  logic                        q_pop,
	output logic                        q_empty,
	output smeu_pkg::instr_t            q_head
);
	import smeu_pkg::*;

	instr_t     cls;
	instr_t     ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		cls.op     = op_t'(req_type);
		cls.ra     = reg_a;
		cls.rb     = reg_b;
		cls.imm    = immediate;
		cls.ip     = current_ip;
		cls.tgt    = jump_target[IP_W-1:0];
		cls.a_ok   = {1'b0, reg_a} < (RIDX_W+1)'(NUM_REGS);
		cls.b_ok   = {1'b0, reg_b} < (RIDX_W+1)'(NUM_REGS);
		cls.tgt_ok = !jump_target[TGT_W-1] && (jump_target[IP_W-1:0] < program_length);
	end

	assign full    = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign q_head  = ent_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && !q_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/smeu_muldiv.sv
// Shared iterative unit: 32x32 unsigned shift-add multiply and restoring divide.
// One bit per cycle. Depends on smeu_pkg.
`default_nettype none
module smeu_muldiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          is_div,
	input  logic [smeu_pkg::WORD_W-1:0]   opa,
	input  logic [smeu_pkg::WORD_W-1:0]   opb,
	output logic                          done,
	output logic [2*smeu_pkg::WORD_W-1:0] res
);
	import smeu_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic              div_q;
	logic [4:0]        cnt_q;
	logic [WORD_W:0]   hi_q;
	logic [WORD_W-1:0] lo_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W:0]   trial;
	logic [WORD_W:0]   diff;
	logic [WORD_W:0]   msum;

	always_comb begin
		trial = {hi_q[WORD_W-1:0], lo_q[WORD_W-1]};
		diff  = trial - {1'b0, b_q};
		msum  = {1'b0, hi_q[WORD_W-1:0]} + (lo_q[0] ? {1'b0, b_q} : '0);
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q <= '0;
			lo_q <= opa;
			b_q  <= opb;
			div_q <= is_div;
		end else if (busy_q) begin
			if (div_q) begin
				hi_q <= diff[WORD_W] ? trial : diff;
				lo_q <= {lo_q[WORD_W-2:0], !diff[WORD_W]};
			end else begin
				hi_q <= {1'b0, msum[WORD_W:1]};
				lo_q <= {msum[0], lo_q[WORD_W-1:1]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 5'd1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign done = done_q;
	assign res  = div_q ? {{WORD_W{1'b0}}, lo_q} : {hi_q[WORD_W-1:0], lo_q};

endmodule
`default_nettype wire

FILE: rtl/core/smeu_back.sv
// Back end: register file, operand stack, execution sequencer and result slot.
// Depends on smeu_pkg and smeu_muldiv.
`default_nettype none
module smeu_back #(
	parameter int NUM_REGS    = 32,
	parameter int STACK_DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  smeu_pkg::instr_t            q_head,
	output logic                        q_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [2:0]                  status,
	output logic [smeu_pkg::WORD_W-1:0] read_value,
	output logic                        ip_written,
	output logic [smeu_pkg::IP_W-1:0]   next_ip
);
	import smeu_pkg::*;

	localparam int RI_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int SI_W = $clog2(STACK_DEPTH);
	localparam int SP_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_EXEC = 3'b010,
		S_MD   = 3'b100
	} state_t;

	state_t              state_q;
	instr_t              ins_q;
	logic [WORD_W-1:0]   rf_a_q;
	logic [WORD_W-1:0]   rf_b_q;
	logic [WORD_W-1:0]   top_q;
	logic [SP_W-1:0]     sp_q;
	logic [SP_W-1:0]     sp_m1;
	logic [WORD_W-1:0]   rf_mem [NUM_REGS];
	logic [NUM_REGS-1:0] rf_vld_q;
	logic [WORD_W-1:0]   stk_mem [STACK_DEPTH];
	logic [RI_W-1:0]     rd_a_idx;
	logic [RI_W-1:0]     rd_b_idx;
	logic [RI_W-1:0]     wr_idx;

	logic              out_vld_q;
	logic [2:0]        status_q;
	logic [WORD_W-1:0] rv_q;
	logic              ipw_q;
	logic [IP_W-1:0]   nip_q;

	logic                st_full;
	logic                st_empty;
	logic                out_free;
	logic                fin;
	logic                go_md;
	logic                md_start;
	logic                md_done;
	logic [2*WORD_W-1:0] md_res;
	logic [WORD_W-1:0]   abs_a;
	logic [WORD_W-1:0]   abs_b;
	logic                neg;
	logic [WORD_W:0]     sum;
	logic                take;
	logic [WORD_W-1:0]   ar_val;
	logic                ar_ovf;

	logic [2:0]        st;
	logic [WORD_W-1:0] rv;
	logic              ipw;
	logic [IP_W-1:0]   nip;
	logic              rf_we;
	logic [WORD_W-1:0] rf_wd;
	logic              stk_we;
	logic [WORD_W-1:0] stk_wd;
	logic              sp_inc;
	logic              sp_dec;

	assign sp_m1    = sp_q - SP_W'(1);
	assign st_full  = sp_q == SP_W'(STACK_DEPTH);
	assign st_empty = sp_q == '0;
	assign out_free = !out_vld_q || pop;
	assign q_pop    = state_q == S_IDLE && !q_empty;
	assign rd_a_idx = q_head.ra[RI_W-1:0];
	assign rd_b_idx = q_head.rb[RI_W-1:0];
	assign wr_idx   = ins_q.ra[RI_W-1:0];

	assign abs_a = rf_a_q[WORD_W-1] ? -rf_a_q : rf_a_q;
	assign abs_b = rf_b_q[WORD_W-1] ? -rf_b_q : rf_b_q;
	assign neg   = rf_a_q[WORD_W-1] ^ rf_b_q[WORD_W-1];

	smeu_muldiv u_md (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (md_start),
		.is_div (ins_q.op == OP_DIV),
		.opa    (abs_a),
		.opb    (abs_b),
		.done   (md_done),
		.res    (md_res)
	);

	// sign fix-up and exact overflow of the iterative result
	always_comb begin
		ar_val = neg ? -md_res[WORD_W-1:0] : md_res[WORD_W-1:0];
		if (ins_q.op == OP_DIV) begin
			ar_ovf = 1'b0;
		end else if (neg) begin
			ar_ovf = (md_res[2*WORD_W-1:WORD_W] != '0) ||
				(md_res[WORD_W-1] && (md_res[WORD_W-2:0] != '0));
		end else begin
			ar_ovf = md_res[2*WORD_W-1:WORD_W-1] != '0;
		end
	end

	always_comb begin
		st     = ST_OK;
		rv     = '0;
		ipw    = 1'b0;
		nip    = '0;
		rf_we  = 1'b0;
		rf_wd  = ins_q.imm;
		stk_we = 1'b0;
		stk_wd = ins_q.imm;
		sp_inc = 1'b0;
		sp_dec = 1'b0;
		go_md  = 1'b0;
		take   = 1'b0;
		sum    = (ins_q.op == OP_SUB) ?
			{rf_a_q[WORD_W-1], rf_a_q} - {rf_b_q[WORD_W-1], rf_b_q} :
			{rf_a_q[WORD_W-1], rf_a_q} + {rf_b_q[WORD_W-1], rf_b_q};
		if (state_q == S_MD) begin
			stk_wd = ar_val;
			if (ar_ovf) st = ST_OVF;
			else if (st_full) st = ST_FULL;
			else begin
				stk_we = 1'b1;
				sp_inc = 1'b1;
			end
		end else begin
			case (ins_q.op)
				OP_HALT: st = ST_HALT;
				OP_DISP: begin
					if (!ins_q.a_ok) st = ST_BADREG;
					else rv = rf_a_q;
				end
				OP_PUSH: begin
					if (st_full) st = ST_FULL;
					else begin
						stk_we = 1'b1;
						sp_inc = 1'b1;
					end
				end
				OP_POP: begin
					if (!ins_q.a_ok) st = ST_BADREG;
					else if (st_empty) st = ST_EMPTY;
					else begin
						sp_dec = 1'b1;
						rf_we  = 1'b1;
						rf_wd  = top_q;
					end
				end
				OP_MOV: begin
					if (!ins_q.a_ok) st = ST_BADREG;
					else rf_we = 1'b1;
				end
				OP_CALL: begin
					stk_wd = WORD_W'(ins_q.ip) + WORD_W'(RET_OFS);
					if (st_full) st = ST_FULL;
					else begin
						stk_we = 1'b1;
						sp_inc = 1'b1;
						if (ins_q.tgt_ok) begin
							ipw = 1'b1;
							nip = ins_q.tgt;
						end else st = ST_BADTGT;
					end
				end
				OP_RET: begin
					if (st_empty) st = ST_EMPTY;
					else begin
						sp_dec = 1'b1;
						ipw    = 1'b1;
						nip    = top_q[IP_W-1:0];
					end
				end
				OP_JMP: begin
					if (ins_q.tgt_ok) begin
						ipw = 1'b1;
						nip = ins_q.tgt;
					end else st = ST_BADTGT;
				end
				OP_JZ, OP_JPOS, OP_JNEG: begin
					if (st_empty) st = ST_EMPTY;
					else begin
						sp_dec = 1'b1;
						if (ins_q.op == OP_JZ) take = top_q == '0;
						else if (ins_q.op == OP_JPOS)
							take = !top_q[WORD_W-1] && (top_q != '0);
						else take = top_q[WORD_W-1];
						if (take) begin
							if (ins_q.tgt_ok) begin
								ipw = 1'b1;
								nip = ins_q.tgt;
							end else st = ST_BADTGT;
						end
					end
				end
				OP_ADD, OP_SUB: begin
					stk_wd = sum[WORD_W-1:0];
					if (!ins_q.a_ok || !ins_q.b_ok) st = ST_BADREG;
					else if (sum[WORD_W] != sum[WORD_W-1]) st = ST_OVF;
					else if (st_full) st = ST_FULL;
					else begin
						stk_we = 1'b1;
						sp_inc = 1'b1;
					end
				end
				OP_MUL: begin
					if (!ins_q.a_ok || !ins_q.b_ok) st = ST_BADREG;
					else go_md = 1'b1;
				end
				OP_DIV: begin
					if (!ins_q.a_ok || !ins_q.b_ok) st = ST_BADREG;
					else if (rf_a_q == WORD_MIN && rf_b_q == WORD_NEG1) st = ST_OVF;
					else if (rf_b_q == '0) st = ST_DIVZERO;
					else go_md = 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign md_start = state_q == S_EXEC && go_md;
	assign fin = out_free && ((state_q == S_EXEC && !go_md) || (state_q == S_MD && md_done));

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ins_q  <= q_head;
			rf_a_q <= rf_vld_q[rd_a_idx] ? rf_mem[rd_a_idx] : '0;
			rf_b_q <= rf_vld_q[rd_b_idx] ? rf_mem[rd_b_idx] : '0;
			top_q  <= stk_mem[sp_m1[SI_W-1:0]];
		end
		if (fin && rf_we) rf_mem[wr_idx] <= rf_wd;
		if (fin && stk_we) stk_mem[sp_q[SI_W-1:0]] <= stk_wd;
		if (fin) begin
			status_q <= st;
			rv_q     <= rv;
			ipw_q    <= ipw;
			nip_q    <= nip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sp_q      <= '0;
			rf_vld_q  <= '0;
			out_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (q_pop) state_q <= S_EXEC;
				S_EXEC: begin
					if (go_md) state_q <= S_MD;
					else if (fin) state_q <= S_IDLE;
				end
				S_MD: if (fin) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (fin && rf_we) rf_vld_q[wr_idx] <= 1'b1;
			if (fin && sp_inc) sp_q <= sp_q + SP_W'(1);
			else if (fin && sp_dec) sp_q <= sp_m1;
			if (fin) out_vld_q <= 1'b1;
			else if (pop) out_vld_q <= 1'b0;
		end
	end

	assign empty      = !out_vld_q;
	assign status     = status_q;
	assign read_value = rv_q;
	assign ip_written = ipw_q;
	assign next_ip    = nip_q;

endmodule
`default_nettype wire

FILE: rtl/core/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: APB config register and the
// front and back ends. Depends on smeu_pkg, smeu_front, smeu_back.
//
// Executes one decoded instruction per transaction. An accepted instruction
// waits in the input queue; when taken from it, it reads the register file
// and stack memory, and its result is registered into the output slot on the
// result ports. The back end takes the next instruction from the queue only
// once the previous one has completed; the input queue can accept further
// instructions meanwhile. Mul and div without an early error pass through
// the shared one-bit-per-cycle multiply/divide unit before their result is
// registered. While a finished result waits in the output slot, the next
// instruction is read but does not complete until the slot frees.
// program_length sits at byte address 0 and may be written only while idle.
`default_nettype none
module stack_machine_execute_unit #(
	parameter int NUM_REGS    = 32,
	parameter int STACK_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [1:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               push,
	output logic                               full,
	input  logic [3:0]                         req_type,
	input  logic [smeu_pkg::RIDX_W-1:0]        reg_a,
	input  logic [smeu_pkg::RIDX_W-1:0]        reg_b,
	input  logic signed [smeu_pkg::WORD_W-1:0] immediate,
	input  logic signed [smeu_pkg::TGT_W-1:0]  jump_target,
	input  logic [smeu_pkg::IP_W-1:0]          current_ip,
	output logic                               empty,
	input  logic                               pop,
	output logic [2:0]                         status,
	output logic signed [smeu_pkg::WORD_W-1:0] read_value,
	output logic                               ip_written,
	output logic [smeu_pkg::IP_W-1:0]          next_ip
);
	import smeu_pkg::*;

	logic [IP_W-1:0] plen_q;
	logic            q_pop;
	logic            q_empty;
	instr_t          q_head;

	assign pready = 1'b1;
	assign prdata = (paddr == '0) ? {16'b0, plen_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plen_q <= PLEN_RST;
		end else if (psel && penable && pwrite && pready) begin
			plen_q <= pwdata[IP_W-1:0];
		end
	end

	smeu_front #(.NUM_REGS(NUM_REGS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.req_type       (req_type),
		.reg_a          (reg_a),
		.reg_b          (reg_b),
		.immediate      (immediate),
		.jump_target    (jump_target),
		.current_ip     (current_ip),
		.program_length (plen_q),
		.q_pop          (q_pop),
		.q_empty        (q_empty),
		.q_head         (q_head)
	);

	smeu_back #(.NUM_REGS(NUM_REGS), .STACK_DEPTH(STACK_DEPTH)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_head     (q_head),
		.q_pop      (q_pop),
		.pop        (pop),
		.empty      (empty),
		.status     (status),
		.read_value (read_value),
		.ip_written (ip_written),
		.next_ip    (next_ip)
	);

endmodule
`default_nettype wire

FILE: rtl/core/smeu_checker.sv
// Port-level checks of the stack machine execute unit, bound to the top level.
// Depends on smeu_pkg.
`default_nettype none
module smeu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  status,
	input logic [31:0] read_value,
	input logic        ip_written,
	input logic [15:0] next_ip
);
	import smeu_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(status) && $stable(next_ip))
		else $error("waiting result changed");

	a_rv_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && read_value != '0 |-> status == ST_OK && !ip_written)
		else $error("read value on a non-display result");

	a_ipw_ok: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && ip_written |-> status == ST_OK)
		else $error("ip written on failed transaction");

	a_nip: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !ip_written |-> next_ip == '0)
		else $error("next ip without ip written");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.status     (status),
	.read_value (read_value),
	.ip_written (ip_written),
	.next_ip    (next_ip)
);
`default_nettype wire
